[sv/cft_pkg.sv]
// cft_pkg: types, limits and character codes shared by the CSV field tokenizer.
// Depends on nothing; every other file of the block uses it.
`default_nettype none
package cft_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int FIELD_BYTES = 256;
  localparam int ROW_LIMIT   = 65536;

  localparam int ColW = $clog2(MAX_COLUMNS + 1);
  localparam int LenW = $clog2(FIELD_BYTES);
  localparam int RowW = $clog2(ROW_LIMIT + 2);

  localparam int QueueDepth = 4;
  localparam int PtrW       = $clog2(QueueDepth);

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [1:0] {
    EV_BYTE = 2'd0,
    EV_EOF  = 2'd1,
    EV_EOR  = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    MODE_REC_START = 5'b00001,
    MODE_FLD_START = 5'b00010,
    MODE_PLAIN     = 5'b00100,
    MODE_QUOTED    = 5'b01000,
    MODE_QSEEN     = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  field_byte;
    logic [5:0]  column_index;
    logic [16:0] row_index;
    logic        last_of_run;
  } out_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [5:0]  col;
    logic [16:0] row;
  } evt_t;

  // One queue entry carries the events of one input byte: one or two.
  typedef struct packed {
    logic two;
    evt_t ev0;
    evt_t ev1;
  } entry_t;

endpackage
`default_nettype wire

[sv/csv_field_tokenizer.sv]
// csv_field_tokenizer: top level of the byte-serial CSV field tokenizer.
// Depends on cft_pkg, cft_front, cft_queue and cft_back.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one beat per
//   text byte with a final_byte flag on the last byte of the stream.
//   Output channel (out_valid_o / out_ready_i / out_data_o) gives field
//   bytes, end-of-field and end-of-record beats tagged with column and row;
//   last_of_run marks the last beat caused by one input byte.
//   An accepted byte's events are registered in the queue; its first
//   result beat is driven from the queue head. One byte per cycle is taken
//   while the queue is not full; a byte with two beats holds the single
//   output port of the sequencer for both. Bytes with no beat push nothing.
//   A four-entry queue between parser and sequencer lets each side stall
//   alone: with the receiver stalled, up to four bytes' worth of beats are
//   held, then in_ready_o drops until beats drain.
//   Reset clears the parse state to start of record, row and column zero,
//   and empties the queue; no beats are pending after reset.
`default_nettype none
module csv_field_tokenizer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cft_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cft_pkg::out_beat_t      out_data_o
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  cft_pkg::entry_t push_data;
  cft_pkg::entry_t head;

  cft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cft_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .empty_o     (empty),
    .pop_i       (pop),
    .head_o      (head)
  );

  cft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[sv/cft_front.sv]
// cft_front: accepts text bytes, runs the CSV parse state and builds the
// events of each byte as one queue entry. Depends on cft_pkg.
`default_nettype none
module cft_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cft_pkg::in_beat_t in_data_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output cft_pkg::entry_t        push_data_o
);

  cft_pkg::mode_e              mode_q, mode_d;
  logic [cft_pkg::ColW-1:0]    col_q, col_d;
  logic [cft_pkg::LenW-1:0]    flen_q, flen_d;
  logic [cft_pkg::RowW-1:0]    row_q, row_d;
  logic                        cr_q, cr_d;
  logic [1:0]                  n_ev;
  cft_pkg::evt_t               ev0, ev1;
  logic                        accept;

  function automatic logic emit_ok(cft_pkg::kind_e k, logic [cft_pkg::ColW-1:0] c,
                                   logic [cft_pkg::RowW-1:0] r);
    return (r <= cft_pkg::RowW'(cft_pkg::ROW_LIMIT)) &&
           ((c < cft_pkg::ColW'(cft_pkg::MAX_COLUMNS)) || (k == cft_pkg::EV_EOR));
  endfunction

  function automatic cft_pkg::evt_t mk_evt(cft_pkg::kind_e k, logic [7:0] b,
                                           logic [cft_pkg::ColW-1:0] c,
                                           logic [cft_pkg::RowW-1:0] r);
    cft_pkg::evt_t e;
    logic [cft_pkg::ColW-1:0] cc;
    cc = (c >= cft_pkg::ColW'(cft_pkg::MAX_COLUMNS)) ?
         cft_pkg::ColW'(cft_pkg::MAX_COLUMNS - 1) : c;
    e.kind = k;
    e.data = (k == cft_pkg::EV_BYTE) ? b : 8'd0;
    e.col  = 6'(cc);
    e.row  = 17'(r);
    return e;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [7:0] b;
    logic       skip;
    logic       do_ef;
    logic       do_pb;
    logic       do_er;
    b      = in_data_i.text_byte;
    mode_d = mode_q;
    col_d  = col_q;
    flen_d = flen_q;
    row_d  = row_q;
    n_ev   = 2'd0;
    ev0    = '0;
    ev1    = '0;
    skip   = cr_q && (b == cft_pkg::ChLf);
    cr_d   = (b == cft_pkg::ChCr) && !in_data_i.final_byte;
    do_ef  = 1'b0;
    do_pb  = 1'b0;
    do_er  = 1'b0;

    // Classify the byte against the current mode.
    if (!skip) begin
      if (b == cft_pkg::ChCr || b == cft_pkg::ChLf) begin
        do_er = (mode_q != cft_pkg::MODE_REC_START);
      end else begin
        case (mode_q)
          cft_pkg::MODE_PLAIN: begin
            if (b == cft_pkg::ChComma) begin
              do_ef  = 1'b1;
              mode_d = cft_pkg::MODE_FLD_START;
            end else begin
              do_pb = 1'b1;
            end
          end
          cft_pkg::MODE_QUOTED: begin
            if (b == cft_pkg::ChQuote) begin
              mode_d = cft_pkg::MODE_QSEEN;
            end else begin
              do_pb = 1'b1;
            end
          end
          cft_pkg::MODE_QSEEN: begin
            if (b == cft_pkg::ChQuote) begin
              do_pb  = 1'b1;
              mode_d = cft_pkg::MODE_QUOTED;
            end else if (b == cft_pkg::ChComma) begin
              do_ef  = 1'b1;
              mode_d = cft_pkg::MODE_FLD_START;
            end else begin
              do_ef  = 1'b1;
              do_pb  = 1'b1;
              mode_d = cft_pkg::MODE_PLAIN;
            end
          end
          default: begin
            if (b == cft_pkg::ChQuote) begin
              mode_d = cft_pkg::MODE_QUOTED;
            end else if (b == cft_pkg::ChComma) begin
              do_ef  = 1'b1;
              mode_d = cft_pkg::MODE_FLD_START;
            end else begin
              do_pb  = 1'b1;
              mode_d = cft_pkg::MODE_PLAIN;
            end
          end
        endcase
      end
    end

    if (do_ef) begin
      if (emit_ok(cft_pkg::EV_EOF, col_d, row_d)) begin
        ev0  = mk_evt(cft_pkg::EV_EOF, 8'd0, col_d, row_d);
        n_ev = 2'd1;
      end
      if (col_d < cft_pkg::ColW'(cft_pkg::MAX_COLUMNS)) col_d = col_d + 1'b1;
      flen_d = '0;
    end

    if (do_pb && (flen_d < cft_pkg::LenW'(cft_pkg::FIELD_BYTES - 1))) begin
      if (emit_ok(cft_pkg::EV_BYTE, col_d, row_d)) begin
        if (n_ev == 2'd0) ev0 = mk_evt(cft_pkg::EV_BYTE, b, col_d, row_d);
        else              ev1 = mk_evt(cft_pkg::EV_BYTE, b, col_d, row_d);
        n_ev = n_ev + 2'd1;
      end
      flen_d = flen_d + 1'b1;
    end

    // Last byte closes an open record; only two events fit, so drop the second.
    if (in_data_i.final_byte && mode_d != cft_pkg::MODE_REC_START) begin
      do_er = 1'b1;
      if (n_ev == 2'd2) n_ev = 2'd1;
    end

    if (do_er) begin
      if (emit_ok(cft_pkg::EV_EOR, col_d, row_d) && n_ev != 2'd2) begin
        if (n_ev == 2'd0) ev0 = mk_evt(cft_pkg::EV_EOR, 8'd0, col_d, row_d);
        else              ev1 = mk_evt(cft_pkg::EV_EOR, 8'd0, col_d, row_d);
        n_ev = n_ev + 2'd1;
      end
      col_d  = '0;
      flen_d = '0;
      mode_d = cft_pkg::MODE_REC_START;
      if (row_d <= cft_pkg::RowW'(cft_pkg::ROW_LIMIT)) row_d = row_d + 1'b1;
    end
  end

  assign push_o           = accept && (n_ev != 2'd0);
  assign push_data_o.two  = (n_ev == 2'd2);
  assign push_data_o.ev0  = ev0;
  assign push_data_o.ev1  = ev1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cft_pkg::MODE_REC_START;
      col_q  <= '0;
      flen_q <= '0;
      row_q  <= '0;
      cr_q   <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      col_q  <= col_d;
      flen_q <= flen_d;
      row_q  <= row_d;
      cr_q   <= cr_d;
    end
  end

endmodule
`default_nettype wire

[sv/cft_queue.sv]
// cft_queue: small FIFO of event entries between the parse front and the
// output sequencer. Depends on cft_pkg.
`default_nettype none
module cft_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire cft_pkg::entry_t push_data_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output cft_pkg::entry_t      head_o
);

  cft_pkg::entry_t            mem_q [cft_pkg::QueueDepth];
  logic [cft_pkg::PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [cft_pkg::PtrW:0]     count_q, count_d;

  assign full_o  = (count_q == (cft_pkg::PtrW + 1)'(cft_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

[sv/cft_back.sv]
// cft_back: walks the events of the head queue entry out as result beats
// and marks the last one of each byte. Depends on cft_pkg.
`default_nettype none
module cft_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire cft_pkg::entry_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output cft_pkg::out_beat_t   out_data_o
);

  logic          sel_q, sel_d;
  logic          last;
  logic          beat;
  cft_pkg::evt_t ev;

  assign ev   = sel_q ? head_i.ev1 : head_i.ev0;
  assign last = sel_q || !head_i.two;
  assign beat = out_valid_o && out_ready_i;

  assign out_valid_o             = !empty_i;
  assign out_data_o.event_kind   = ev.kind;
  assign out_data_o.field_byte   = ev.data;
  assign out_data_o.column_index = ev.col;
  assign out_data_o.row_index    = ev.row;
  assign out_data_o.last_of_run  = last;

  // Advance within the entry; pop it after its last event.
  assign pop_o = beat && last;
  assign sel_d = beat ? !last : sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule
`default_nettype wire

[tb/cft_checker.sv]
`timescale 1ns / 1ps
// cft_checker: watches both channels of the CSV field tokenizer, predicts the
// tokens of every accepted text byte and compares them with the output beats.
// Depends on cft_pkg for the beat types, limits and character codes.
module cft_checker
  import cft_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_beat_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        bytes_seen_o,
  output int        beats_seen_o
);

  // Parser state as the block should hold it.
  mode_e       pm;
  logic [6:0]  col_cnt;
  logic [8:0]  fld_len;
  logic [16:0] row_cnt;
  logic        after_cr;

  // Tokens of the byte being parsed, then the queue of tokens still due.
  out_beat_t   step_res [2];
  int          step_n;
  out_beat_t   tokens_due [$];

  out_beat_t   want_beat;
  int          fails = 0;
  int          shown = 0;
  int          bytes_seen = 0;
  int          beats_seen = 0;

  task automatic emit_token(input kind_e k, input logic [7:0] b);
    out_beat_t r;
    if (row_cnt > ROW_LIMIT || step_n >= 2) return;
    if (col_cnt >= MAX_COLUMNS) begin
      // Past the last column only the end of record gets out.
      if (k != EV_EOR) return;
      r.column_index = 6'(MAX_COLUMNS - 1);
    end else begin
      r.column_index = col_cnt[5:0];
    end
    r.event_kind  = k;
    r.field_byte  = (k == EV_BYTE) ? b : 8'h00;
    r.row_index   = row_cnt;
    r.last_of_run = 1'b0;
    step_res[step_n] = r;
    step_n++;
  endtask

  task automatic keep_byte(input logic [7:0] b);
    if (fld_len < FIELD_BYTES - 1) begin
      emit_token(EV_BYTE, b);
      fld_len++;
    end
  endtask

  task automatic close_field();
    emit_token(EV_EOF, 8'h00);
    if (col_cnt < MAX_COLUMNS) col_cnt++;
    fld_len = '0;
  endtask

  task automatic close_record();
    emit_token(EV_EOR, 8'h00);
    col_cnt = '0;
    fld_len = '0;
    pm      = MODE_REC_START;
    if (row_cnt <= ROW_LIMIT) row_cnt++;
  endtask

  task automatic tokenize_byte(input in_beat_t beat);
    logic [7:0] b;
    logic       skip;
    b = beat.text_byte;
    step_n = 0;
    skip = after_cr && (b == ChLf);
    after_cr = (b == ChCr);
    if (!skip) begin
      if (b == ChCr || b == ChLf) begin
        if (pm != MODE_REC_START) close_record();
      end else begin
        case (pm)
          MODE_PLAIN: begin
            if (b == ChComma) begin
              close_field();
              pm = MODE_FLD_START;
            end else begin
              keep_byte(b);
            end
          end
          MODE_QUOTED: begin
            if (b == ChQuote) pm = MODE_QSEEN;
            else keep_byte(b);
          end
          MODE_QSEEN: begin
            if (b == ChQuote) begin
              keep_byte(b);
              pm = MODE_QUOTED;
            end else if (b == ChComma) begin
              close_field();
              pm = MODE_FLD_START;
            end else begin
              // Stray byte after the closing quote opens a new plain field.
              close_field();
              keep_byte(b);
              pm = MODE_PLAIN;
            end
          end
          default: begin
            if (b == ChQuote) begin
              pm = MODE_QUOTED;
            end else if (b == ChComma) begin
              close_field();
              pm = MODE_FLD_START;
            end else begin
              keep_byte(b);
              pm = MODE_PLAIN;
            end
          end
        endcase
      end
    end
    if (beat.final_byte) begin
      if (pm != MODE_REC_START) begin
        // Drop the second token so the end of record still fits.
        if (step_n >= 2) step_n = 1;
        close_record();
      end
      after_cr = 1'b0;
    end
    for (int i = 0; i < step_n; i++) begin
      step_res[i].last_of_run = (i == step_n - 1);
      tokens_due.push_back(step_res[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm       = MODE_REC_START;
      col_cnt  = '0;
      fld_len  = '0;
      row_cnt  = '0;
      after_cr = 1'b0;
      tokens_due.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        bytes_seen++;
        tokenize_byte(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        beats_seen++;
        if (tokens_due.size() == 0) begin
          fails++;
          if (shown < 30) begin
            shown++;
            $display("%0t: unexpected beat: kind %0d byte %02h col %0d row %0d last %0d",
                     $time, out_data_i.event_kind, out_data_i.field_byte,
                     out_data_i.column_index, out_data_i.row_index, out_data_i.last_of_run);
          end
        end else begin
          want_beat = tokens_due.pop_front();
          if (out_data_i.event_kind !== want_beat.event_kind ||
              out_data_i.field_byte !== want_beat.field_byte ||
              out_data_i.column_index !== want_beat.column_index ||
              out_data_i.row_index !== want_beat.row_index ||
              out_data_i.last_of_run !== want_beat.last_of_run) begin
            fails++;
            if (shown < 30) begin
              shown++;
              $display("%0t: mismatch: expected kind %0d byte %02h col %0d row %0d last %0d",
                       $time, want_beat.event_kind, want_beat.field_byte,
                       want_beat.column_index, want_beat.row_index, want_beat.last_of_run);
              $display("%0t:           actual kind %0d byte %02h col %0d row %0d last %0d",
                       $time, out_data_i.event_kind, out_data_i.field_byte,
                       out_data_i.column_index, out_data_i.row_index,
                       out_data_i.last_of_run);
            end
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= tokens_due.size();
    bytes_seen_o <= bytes_seen;
    beats_seen_o <= beats_seen;
  end

endmodule

[tb/tb_csv_field_tokenizer.sv]
`timescale 1ns / 1ps
// tb_csv_field_tokenizer: drives CSV text into the tokenizer under four idling
// mixes and a receiver hold-off; cft_checker does the checking.
// Depends on cft_pkg, cft_checker and the csv_field_tokenizer RTL.
module tb_csv_field_tokenizer;
  import cft_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  int        tx_gap_pct = 0;
  int        rx_stall_pct = 0;
  bit        hold_rx = 1'b0;
  int        sent_bytes = 0;

  int        fail_count;
  int        pending;
  int        bytes_seen;
  int        beats_seen;

  csv_field_tokenizer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  cft_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .bytes_seen_o (bytes_seen),
    .beats_seen_o (beats_seen)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d beats still due", pending);
    $display("Some tests failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  // Valid stays up with the old byte until the next call decides.
  task automatic send_beat(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_byte: b, final_byte: fin};
    do @(posedge clk); while (in_ready !== 1'b1);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic set_phase(input int tx_pct, input int rx_pct);
    in_valid <= 1'b0;
    @(posedge clk);
    tx_gap_pct   = tx_pct;
    rx_stall_pct = rx_pct;
    @(negedge clk);
  endtask

  task automatic hold_receiver(input int cycles);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_rx = 1'b0;
  endtask

  function automatic logic [7:0] pick_byte(input bit no_comma, input bit no_quote);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ChCr || b == ChLf || (no_comma && b == ChComma) ||
           (no_quote && b == ChQuote));
    return b;
  endfunction

  task automatic send_record();
    int ncol;
    int len;
    bit wide;
    wide = ($urandom_range(0, 29) == 0);
    ncol = wide ? $urandom_range(62, 70) : $urandom_range(1, 6);
    if ($urandom_range(0, 15) == 0) send_beat($urandom_range(0, 1) ? ChCr : ChLf, 1'b0);
    for (int c = 0; c < ncol; c++) begin
      if (c > 0) send_beat(ChComma, 1'b0);
      if (wide) len = $urandom_range(0, 2);
      else if ($urandom_range(0, 59) == 0) len = $urandom_range(250, 300);
      else len = $urandom_range(0, 8);
      if ($urandom_range(0, 2) == 0) begin
        send_beat(ChQuote, 1'b0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_beat(ChQuote, 1'b0);
            send_beat(ChQuote, 1'b0);
          end else begin
            send_beat(pick_byte(1'b0, 1'b1), 1'b0);
          end
        end
        send_beat(ChQuote, 1'b0);
        if ($urandom_range(0, 9) == 0) send_beat(pick_byte(1'b1, 1'b1), 1'b0);
      end else begin
        for (int i = 0; i < len; i++) send_beat(pick_byte(1'b1, 1'b1), 1'b0);
      end
    end
    case ($urandom_range(0, 6))
      0: send_beat(ChLf, 1'b0);
      1: send_beat(ChCr, 1'b0);
      2, 3: begin
        send_beat(ChCr, 1'b0);
        send_beat(ChLf, 1'b0);
      end
      4: send_beat(pick_byte(1'b1, 1'b1), 1'b1);
      5: send_beat(ChCr, 1'b1);
      default: send_beat(ChLf, 1'b1);
    endcase
  endtask

  task automatic random_block(input int nbytes);
    int start;
    int burst;
    logic [7:0] b;
    start = sent_bytes;
    while (sent_bytes - start < nbytes) begin
      if ($urandom_range(0, 99) < 12) begin
        // Noise: raw bytes, weighted toward the special characters.
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          case ($urandom_range(0, 7))
            0: b = ChQuote;
            1: b = ChComma;
            2: b = ChCr;
            3: b = ChLf;
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_beat(b, $urandom_range(0, 15) == 0);
        end
      end else begin
        send_record();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Header with a doubled quote, ended by CR LF.
    set_phase(0, 0);
    send_str("a,\"b\"\"c\"", 1'b0);
    send_beat(ChCr, 1'b0);
    send_beat(ChLf, 1'b0);
    // Blank line, then a stray byte after a closing quote and the byte extremes.
    send_beat(ChLf, 1'b0);
    send_str("\"x\"y,", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(ChLf, 1'b0);
    // Line break inside a quoted field, then final byte right after a closing quote.
    send_str("\"p", 1'b0);
    send_beat(ChCr, 1'b0);
    send_str("\"z\"w", 1'b1);

    random_block(120);
    set_phase(73, 0);
    random_block(120);
    set_phase(0, 73);
    random_block(120);
    set_phase(19, 19);
    random_block(120);

    // Hold the receiver off while the sender keeps offering bytes.
    set_phase(0, 0);
    fork
      hold_receiver(200);
      begin
        random_block(60);
        in_valid <= 1'b0;
      end
    join
    @(negedge clk);
    set_phase(0, 0);

    for (int k = 0; k < 10000 && pending != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);

    if (pending != 0) $display("%0t: %0d expected beats never arrived", $time, pending);
    $display("Sent %0d text bytes and checked %0d beats: quoting, CR/LF, blank lines,",
             bytes_seen, beats_seen);
    $display("long fields, wide rows, four idle mixes and a receiver hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/cft_pkg.sv
sv/cft_front.sv
sv/cft_queue.sv
sv/cft_back.sv
sv/csv_field_tokenizer.sv
tb/cft_checker.sv
tb/tb_csv_field_tokenizer.sv
